/* hdl/mpbf_pkg.sv */
// Package for the multi-pipe byte FIFO manager: beat structs, command and
// status codes, descriptor kinds and controller states. No dependencies.
`timescale 1ns / 1ps
package mpbf_pkg;

  localparam logic [30:0] DESC_BASE = 31'h4000_0000;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLOSE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_DESC = 3'd1,
    ST_FULL     = 3'd2,
    ST_WBLOCK   = 3'd3,
    ST_EOS      = 3'd4,
    ST_NO_ROOM  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_RBYTE,
    S_RWAIT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [30:0] descriptor;
    logic [7:0]  data_byte;
    logic [6:0]  byte_count;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [30:0] read_end;
    logic [30:0] write_end;
    logic [12:0] buffered_count;
    logic        last;
  } result_beat_t;

endpackage

/* hdl/mpbf_storage.sv */
// Byte storage for all pipes: one synchronous RAM, one read port with a
// registered output. Depends on nothing but its parameters.
`timescale 1ns / 1ps
module mpbf_storage #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/multi_pipe_byte_fifo_manager.sv */
// Top level of the multi-pipe byte FIFO manager: descriptor table, pipe
// pointer table, command sequencer. Uses mpbf_pkg and mpbf_storage.
//
// Usage: drive a command beat on cmd_in with start high while busy is low.
// Results appear on result with strobe high for exactly one cycle each;
// result.last marks the final beat of a command. The receiver cannot stall.
// Create, write and close give one result: the tables are read (S_LOOK),
// the command is decided (S_DECIDE) and the beat is registered onto
// result. A read gives its bytes one at a time through S_RBYTE and S_RWAIT:
// each byte needs a storage read and a head/fill update of the pipe's
// pointer entry.
// busy drops in the cycle that carries the last result of a command.
// Free descriptors and free pipes are found by priority encoders over
// their state flops (the tables are small). Byte storage is one RAM of
// 2**(PW+HW) bytes (NUM_PIPES*PIPE_DEPTH for powers of two); its
// contents are undefined after reset and only ever read at written positions.
// Reset (rst, synchronous) frees all descriptors and pipes at once.
`timescale 1ns / 1ps
module multi_pipe_byte_fifo_manager import mpbf_pkg::*; #(
  parameter int NUM_DESCRIPTORS = 32,
  parameter int PIPE_DEPTH      = 4096,
  parameter int NUM_PIPES       = 16,
  parameter int MAX_READ_BURST  = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  cmd_beat_t    cmd_in,
  output logic         busy,
  output logic         strobe,
  output result_beat_t result
);

  localparam int DW = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;
  localparam int PW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int HW = $clog2(PIPE_DEPTH);
  localparam int FW = HW + 1;
  localparam int AW = PW + HW;

  // descriptor and pipe tables, in flops
  kind_t         desc_kind  [NUM_DESCRIPTORS];
  logic [PW-1:0] desc_pipe  [NUM_DESCRIPTORS];
  logic          pipe_used  [NUM_PIPES];
  logic [HW-1:0] pipe_head  [NUM_PIPES];
  logic [FW-1:0] pipe_fill  [NUM_PIPES];
  logic [1:0]    pipe_refs  [NUM_PIPES];

  state_t    state, state_next;
  cmd_beat_t cur;
  logic          valid_d;
  logic [DW-1:0] slot;
  logic [PW-1:0] pipe;
  kind_t         kind;
  logic [HW-1:0] head;
  logic [FW-1:0] fill;
  logic [1:0]    refs;
  logic [6:0]    remain;
  logic          r_ok, w_ok, p_ok;
  logic [DW-1:0] r_idx, w_idx;
  logic [PW-1:0] p_idx;

  logic [7:0] rd_data;
  logic       wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic         strobe_next;
  result_beat_t result_next;

  logic [30:0] offs;
  logic        in_range;
  assign offs     = cur.descriptor - DESC_BASE;
  assign in_range = (cur.descriptor >= DESC_BASE) && (offs < 31'(NUM_DESCRIPTORS));

  // free descriptor and free pipe search
  always_comb begin
    r_ok = 1'b0; w_ok = 1'b0; p_ok = 1'b0;
    r_idx = '0; w_idx = '0; p_idx = '0;
    for (int i = NUM_DESCRIPTORS - 1; i >= 0; i--) begin
      if (desc_kind[i] == KIND_FREE) begin
        w_idx = r_idx; w_ok = r_ok;
        r_idx = DW'(i); r_ok = 1'b1;
      end
    end
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!pipe_used[i]) begin
        p_idx = PW'(i); p_ok = 1'b1;
      end
    end
  end

  // storage address: pipe and head for reads, pipe and tail for writes
  logic [FW-1:0] tail_sum;
  assign tail_sum = FW'(head) + fill;
  assign rd_addr  = {pipe, head};
  assign wr_addr  = {pipe, (tail_sum >= FW'(PIPE_DEPTH)) ?
                     HW'(tail_sum - FW'(PIPE_DEPTH)) : HW'(tail_sum)};
  assign wr_en = (state == S_DECIDE) && (cur.cmd == CMD_WRITE) && valid_d &&
                 (kind == KIND_WRITE) && (fill < FW'(PIPE_DEPTH));

  mpbf_storage #(.ADDR_W(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(cur.data_byte),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign busy = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_LOOK;
      S_LOOK:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (cur.cmd == CMD_READ && valid_d && kind == KIND_READ &&
            fill != '0 && remain != '0) begin
          state_next = S_RBYTE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RBYTE:  state_next = S_RWAIT;
      S_RWAIT:  state_next = (remain == 7'd1 || fill == FW'(1)) ? S_IDLE : S_RBYTE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // result beat for the current step
  always_comb begin
    strobe_next = 1'b0;
    result_next = '0;
    result_next.last = 1'b1;
    case (state)
      S_DECIDE: begin
        case (cur.cmd)
          CMD_CREATE: begin
            strobe_next = 1'b1;
            if (!(r_ok && w_ok && p_ok)) begin
              result_next.status = ST_NO_ROOM;
            end else begin
              result_next.status    = ST_OK;
              result_next.read_end  = DESC_BASE + 31'(r_idx);
              result_next.write_end = DESC_BASE + 31'(w_idx);
            end
          end
          CMD_WRITE: begin
            strobe_next = 1'b1;
            if (!valid_d || kind != KIND_WRITE)   result_next.status = ST_BAD_DESC;
            else if (fill >= FW'(PIPE_DEPTH))     result_next.status = ST_FULL;
            else                                  result_next.status = ST_OK;
          end
          CMD_READ: begin
            if (!valid_d || kind != KIND_READ) begin
              strobe_next = 1'b1;
              result_next.status = ST_BAD_DESC;
            end else if (fill == '0) begin
              strobe_next = 1'b1;
              result_next.status = (refs > 2'd1) ? ST_WBLOCK : ST_EOS;
            end else if (remain == '0) begin
              strobe_next = 1'b1;
              result_next.status = ST_OK;
              result_next.buffered_count = 13'(fill);
            end
          end
          CMD_CLOSE: begin
            strobe_next = 1'b1;
            result_next.status = valid_d ? ST_OK : ST_BAD_DESC;
          end
          default: ;
        endcase
      end
      S_RWAIT: begin
        // byte read from storage is on rd_data now
        strobe_next = 1'b1;
        result_next.status = ST_OK;
        result_next.read_byte = rd_data;
        result_next.buffered_count = 13'(fill - FW'(1));
        result_next.last = (remain == 7'd1 || fill == FW'(1));
      end
      default: ;
    endcase
  end

  // sequencer datapath and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      for (int i = 0; i < NUM_DESCRIPTORS; i++) begin
        desc_kind[i] <= KIND_FREE;
        desc_pipe[i] <= '0;
      end
      for (int i = 0; i < NUM_PIPES; i++) begin
        pipe_used[i] <= 1'b0;
        pipe_head[i] <= '0;
        pipe_fill[i] <= '0;
        pipe_refs[i] <= '0;
      end
    end else begin
      strobe <= strobe_next;
      result <= result_next;
      case (state)
        S_IDLE: if (start) cur <= cmd_in;
        S_LOOK: begin
          // register the addressed entry
          valid_d <= in_range;
          slot   <= DW'(offs);
          pipe   <= desc_pipe[DW'(offs)];
          kind   <= in_range ? desc_kind[DW'(offs)] : KIND_FREE;
          head   <= pipe_head[desc_pipe[DW'(offs)]];
          fill   <= pipe_fill[desc_pipe[DW'(offs)]];
          refs   <= pipe_refs[desc_pipe[DW'(offs)]];
          remain <= (cur.byte_count > 7'(MAX_READ_BURST)) ?
                    7'(MAX_READ_BURST) : cur.byte_count;
        end
        S_DECIDE: begin
          case (cur.cmd)
            CMD_CREATE: begin
              if (r_ok && w_ok && p_ok) begin
                desc_kind[r_idx] <= KIND_READ;
                desc_kind[w_idx] <= KIND_WRITE;
                desc_pipe[r_idx] <= p_idx;
                desc_pipe[w_idx] <= p_idx;
                pipe_used[p_idx] <= 1'b1;
                pipe_head[p_idx] <= '0;
                pipe_fill[p_idx] <= '0;
                pipe_refs[p_idx] <= 2'd2;
              end
            end
            CMD_WRITE: begin
              if (wr_en) pipe_fill[pipe] <= fill + FW'(1);
            end
            CMD_CLOSE: begin
              if (valid_d) begin
                if (kind != KIND_FREE) begin
                  if (refs <= 2'd1) begin
                    pipe_refs[pipe] <= '0;
                    pipe_used[pipe] <= 1'b0;
                    pipe_head[pipe] <= '0;
                    pipe_fill[pipe] <= '0;
                  end else begin
                    pipe_refs[pipe] <= refs - 2'd1;
                  end
                end
                desc_kind[slot] <= KIND_FREE;
                desc_pipe[slot] <= '0;
              end
            end
            default: ;
          endcase
        end
        S_RBYTE: begin
          // storage read of head is in flight; advance pointers
          head <= (head == HW'(PIPE_DEPTH - 1)) ? '0 : head + HW'(1);
          pipe_head[pipe] <= (head == HW'(PIPE_DEPTH - 1)) ? '0 : head + HW'(1);
          pipe_fill[pipe] <= fill - FW'(1);
        end
        S_RWAIT: begin
          fill   <= fill - FW'(1);
          remain <= remain - 7'd1;
        end
        default: ;
      endcase
    end
  end

endmodule
